/* src/csb_pkg.sv */
// Package for the carrier sense backoff engine: phase and status codes,
// field widths, register indexes, reset values and the state/config/result structs.
// No dependencies.
package csb_pkg;

    // Field widths
    localparam int RSSI_W   = 9;
    localparam int TICKS_W  = 16;
    localparam int RAND_W   = 16;
    localparam int TRIALS_W = 5;
    localparam int TRIAL_W  = 4;
    localparam int STATUS_W = 3;
    localparam int BOFF_W   = 32;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 16;

    // Engine phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SENSE   = 2'd1,
        PH_BACKOFF = 2'd2
    } t_phase;

    // Reported status codes
    localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SENSE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BACKOFF = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_GIVE_UP = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_RSSI_THRESHOLD = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_SENSE_TICKS    = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_BACKOFF_UNIT   = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_MAX_TRIALS     = 2'd3;

    // Register reset values
    localparam logic signed [RSSI_W-1:0] RST_RSSI_THRESHOLD = -9'sd80;
    localparam logic [TICKS_W-1:0]       RST_SENSE_TICKS    = 16'd5;
    localparam logic [TICKS_W-1:0]       RST_BACKOFF_UNIT   = 16'd50;
    localparam logic [TRIALS_W-1:0]      RST_MAX_TRIALS     = 5'd5;

    typedef struct packed {
        logic signed [RSSI_W-1:0] rssi_threshold;
        logic [TICKS_W-1:0]       sense_ticks;
        logic [TICKS_W-1:0]       backoff_unit;
        logic [TRIALS_W-1:0]      max_trials;
    } t_cfg;

    typedef struct packed {
        t_phase               phase;
        logic [TRIAL_W-1:0]   trial_index;
        logic [TICKS_W-1:0]   sense_elapsed;
        logic [BOFF_W-1:0]    backoff_left;
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TRIAL_W-1:0]  trial;
        logic [BOFF_W-1:0]   backoff_ticks;
    } t_result;

endpackage

/* src/csb_step.sv */
// One tick of the listen-before-talk engine: next state and result from the
// current state, the configuration and one input transaction.
// Depends on csb_pkg.
module csb_step
    import csb_pkg::*;
(
    input  t_state                   i_state,
    input  t_cfg                     i_cfg,
    input  logic                     i_start_req,
    input  logic signed [RSSI_W-1:0] i_rssi_sample,
    input  logic [RAND_W-1:0]        i_random_value,
    output t_state                   o_state,
    output t_result                  o_result
);

    logic [TICKS_W-1:0]   window;
    logic [TRIAL_W-1:0]   last_idx;
    logic [TRIAL_W:0]     shift_amt;
    logic [RAND_W-1:0]    slot_mask;
    logic [RAND_W:0]      slots;
    logic [BOFF_W-1:0]    product;
    logic [TICKS_W-1:0]   elapsed_inc;
    logic [BOFF_W-1:0]    left_dec;
    logic                 busy;
    t_state               cur;

    // Clamp the configuration to legal ranges
    always_comb begin
        window = (i_cfg.sense_ticks == '0) ? TICKS_W'(1) : i_cfg.sense_ticks;
        if (i_cfg.max_trials <= TRIALS_W'(1)) begin
            last_idx = '0;
        end else if (i_cfg.max_trials > TRIALS_W'(16)) begin
            last_idx = '1;
        end else begin
            last_idx = TRIAL_W'(i_cfg.max_trials - TRIALS_W'(1));
        end
    end

    // Start request only takes effect from idle
    always_comb begin
        cur = i_state;
        if (i_state.phase == PH_IDLE && i_start_req) begin
            cur.phase         = PH_SENSE;
            cur.trial_index   = '0;
            cur.sense_elapsed = '0;
            cur.backoff_left  = '0;
        end
    end

    // Backoff length: unit * (1 + (random mod 2^(trial+1)))
    always_comb begin
        shift_amt = {1'b0, cur.trial_index} + (TRIAL_W+1)'(1);
        slot_mask = ~({RAND_W{1'b1}} << shift_amt);
        slots     = {1'b0, i_random_value & slot_mask} + (RAND_W+1)'(1);
        product   = BOFF_W'(i_cfg.backoff_unit) * BOFF_W'(slots);
    end

    assign busy        = i_rssi_sample > i_cfg.rssi_threshold;
    assign elapsed_inc = cur.sense_elapsed + TICKS_W'(1);
    assign left_dec    = (cur.backoff_left == '0) ? '0 : cur.backoff_left - BOFF_W'(1);

    // Phase transitions and result
    always_comb begin
        o_state                = cur;
        o_result.status        = ST_IDLE;
        o_result.backoff_ticks = '0;
        case (cur.phase)
            PH_SENSE: begin
                if (busy) begin
                    if (cur.trial_index < last_idx) begin
                        o_result.backoff_ticks = product;
                        o_state.backoff_left   = product;
                        o_state.phase          = PH_BACKOFF;
                        o_result.status        = ST_BACKOFF;
                    end else begin
                        o_state.phase   = PH_IDLE;
                        o_result.status = ST_GIVE_UP;
                    end
                end else begin
                    o_state.sense_elapsed = elapsed_inc;
                    if (elapsed_inc >= window) begin
                        o_state.phase   = PH_IDLE;
                        o_result.status = ST_FREE;
                    end else begin
                        o_result.status = ST_SENSE;
                    end
                end
            end
            PH_BACKOFF: begin
                o_state.backoff_left = left_dec;
                if (left_dec == '0) begin
                    o_state.phase         = PH_SENSE;
                    o_state.trial_index   = cur.trial_index + TRIAL_W'(1);
                    o_state.sense_elapsed = '0;
                end
                o_result.status = ST_BACKOFF;
            end
            default: begin
                o_state.phase   = PH_IDLE;
                o_result.status = ST_IDLE;
            end
        endcase
        o_result.trial = o_state.trial_index;
    end

endmodule

/* src/carrier_sense_backoff_top.sv */
// Listen-before-talk engine with binary exponential backoff, one input
// transaction per time tick. It takes one transaction every clock cycle
// while the result side is not stalled; each passes an input register and
// then a result register before its result is valid. The path between the
// two registers holds the RSSI compare and the 16x17 backoff multiply.
// Depends on csb_pkg and csb_step.
module carrier_sense_backoff_top
    import csb_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [CFG_A_W-1:0]         i_cfg_addr,
    input  logic [CFG_D_W-1:0]         i_cfg_wdata,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_start_req,
    input  logic signed [RSSI_W-1:0]   i_rssi_sample,
    input  logic [RAND_W-1:0]          i_random_value,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic [TRIAL_W-1:0]         o_trial,
    output logic [BOFF_W-1:0]          o_backoff_ticks
);

    t_cfg                     r_cfg;
    t_state                   r_state;
    t_state                   n_state;
    t_result                  n_result;
    t_result                  r_result;
    logic                     r_in_valid;
    logic                     r_start_req;
    logic signed [RSSI_W-1:0] r_rssi_sample;
    logic [RAND_W-1:0]        r_random_value;
    logic                     r_out_valid;
    logic                     fire;

    // Result register free or draining: move the held transaction on
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rssi_threshold <= RST_RSSI_THRESHOLD;
            r_cfg.sense_ticks    <= RST_SENSE_TICKS;
            r_cfg.backoff_unit   <= RST_BACKOFF_UNIT;
            r_cfg.max_trials     <= RST_MAX_TRIALS;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_RSSI_THRESHOLD: r_cfg.rssi_threshold <= i_cfg_wdata[RSSI_W-1:0];
                REG_SENSE_TICKS:    r_cfg.sense_ticks    <= i_cfg_wdata[TICKS_W-1:0];
                REG_BACKOFF_UNIT:   r_cfg.backoff_unit   <= i_cfg_wdata[TICKS_W-1:0];
                REG_MAX_TRIALS:     r_cfg.max_trials     <= i_cfg_wdata[TRIALS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_start_req    <= i_start_req;
            r_rssi_sample  <= i_rssi_sample;
            r_random_value <= i_random_value;
        end
    end

    csb_step u_step (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_start_req    (r_start_req),
        .i_rssi_sample  (r_rssi_sample),
        .i_random_value (r_random_value),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // Engine state advances once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_IDLE;
            r_state.trial_index   <= '0;
            r_state.sense_elapsed <= '0;
            r_state.backoff_left  <= '0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_result.status;
    assign o_trial         = r_result.trial;
    assign o_backoff_ticks = r_result.backoff_ticks;

    // Backoff counter only nonzero while backing off
    a_left_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase != PH_BACKOFF) |-> (r_state.backoff_left == '0))
        else $error("backoff counter nonzero outside backoff");

    // A chosen backoff length is only reported with backoff status
    a_ticks_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_result.backoff_ticks != '0)) |-> (r_result.status == ST_BACKOFF))
        else $error("backoff length reported without backoff status");

    // A moved transaction always lands in the result register
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("transaction lost between input and result register");

    // A stalled input transaction is held, not dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> r_in_valid)
        else $error("held input transaction dropped");

endmodule

/* tb/csb_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for carrier_sense_backoff_top: tracks register writes, predicts one
// result per accepted input transaction and compares results in arrival order.
// Depends on csb_pkg.
module csb_checker
    import csb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_A_W-1:0]       i_cfg_addr,
    input  logic [CFG_D_W-1:0]       i_cfg_wdata,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_start_req,
    input  logic signed [RSSI_W-1:0] i_rssi_sample,
    input  logic [RAND_W-1:0]        i_random_value,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [STATUS_W-1:0]      i_status,
    input  logic [TRIAL_W-1:0]       i_trial,
    input  logic [BOFF_W-1:0]        i_backoff_ticks,
    output int                       o_fail_count,
    output int                       o_pending,
    output logic                     o_engine_active,
    output int                       o_checked,
    output int                       o_grants,
    output int                       o_give_ups,
    output int                       o_deepest_trial
);

    // register shadow
    logic signed [RSSI_W-1:0] busy_level;
    logic [TICKS_W-1:0]       window_len;
    logic [TICKS_W-1:0]       slot_len;
    logic [TRIALS_W-1:0]      trial_cap;

    // engine state as predicted
    t_phase                   eng_phase;
    logic [TRIAL_W-1:0]       eng_trial;
    logic [TICKS_W-1:0]       sensed;
    logic [BOFF_W-1:0]        wait_left;

    t_result                  expected_results[$];
    int                       fails;
    int                       checked;
    int                       grants;
    int                       give_ups;
    int                       deepest;

    // Advance the engine by one tick and return the result (status, trial, backoff length) it reports.
    function automatic t_result run_tick(input logic start,
                                         input logic signed [RSSI_W-1:0] rssi,
                                         input logic [RAND_W-1:0] rnd);
        t_result            res;
        logic [TICKS_W-1:0] window;
        logic [TRIALS_W-1:0] trials;
        logic [BOFF_W-1:0]  slots;
        res = '0;
        window = (window_len == '0) ? TICKS_W'(1) : window_len;
        trials = (trial_cap == '0) ? TRIALS_W'(1) :
                 (trial_cap > 16) ? TRIALS_W'(16) : trial_cap;

        // start request only counts in idle
        if (eng_phase == PH_IDLE && start) begin
            eng_phase = PH_SENSE;
            eng_trial = '0;
            sensed    = '0;
            wait_left = '0;
        end

        case (eng_phase)
            PH_SENSE: begin
                if (rssi > busy_level) begin
                    if (eng_trial < trials - 1) begin
                        // 1 + (random mod 2^(trial+1)) slots
                        slots = ({16'd0, rnd} & ((32'd2 << eng_trial) - 32'd1)) + 32'd1;
                        res.backoff_ticks = BOFF_W'(slot_len) * slots;
                        wait_left  = res.backoff_ticks;
                        eng_phase  = PH_BACKOFF;
                        res.status = ST_BACKOFF;
                    end else begin
                        eng_phase  = PH_IDLE;
                        res.status = ST_GIVE_UP;
                    end
                end else begin
                    sensed = sensed + 1'b1;
                    if (sensed >= window) begin
                        eng_phase  = PH_IDLE;
                        res.status = ST_FREE;
                    end else begin
                        res.status = ST_SENSE;
                    end
                end
            end
            PH_BACKOFF: begin
                if (wait_left != '0)
                    wait_left = wait_left - 1'b1;
                // last backoff tick still reports backoff, sensing resumes next tick
                if (wait_left == '0) begin
                    eng_phase = PH_SENSE;
                    eng_trial = eng_trial + 1'b1;
                    sensed    = '0;
                end
                res.status = ST_BACKOFF;
            end
            default: begin
                eng_phase  = PH_IDLE;
                res.status = ST_IDLE;
            end
        endcase
        res.trial = eng_trial;
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [BOFF_W-1:0] exp_val,
                                        input logic [BOFF_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
            fails++;
        end
    endfunction

    // sample everything at the clock edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            busy_level = RST_RSSI_THRESHOLD;
            window_len = RST_SENSE_TICKS;
            slot_len   = RST_BACKOFF_UNIT;
            trial_cap  = RST_MAX_TRIALS;
            eng_phase  = PH_IDLE;
            eng_trial  = '0;
            sensed     = '0;
            wait_left  = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_RSSI_THRESHOLD: busy_level = i_cfg_wdata[RSSI_W-1:0];
                    REG_SENSE_TICKS:    window_len = i_cfg_wdata[TICKS_W-1:0];
                    REG_BACKOFF_UNIT:   slot_len   = i_cfg_wdata[TICKS_W-1:0];
                    REG_MAX_TRIALS:     trial_cap  = i_cfg_wdata[TRIALS_W-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready)
                expected_results.push_back(run_tick(i_start_req, i_rssi_sample,
                                                    i_random_value));

            // result transaction
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %0d/%0d/%0d",
                             $time, i_status, i_trial, i_backoff_ticks);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", BOFF_W'(want.status), BOFF_W'(i_status));
                    check_field("trial", BOFF_W'(want.trial), BOFF_W'(i_trial));
                    check_field("backoff_ticks", want.backoff_ticks, i_backoff_ticks);
                    checked++;
                    if (want.status == ST_FREE)
                        grants++;
                    if (want.status == ST_GIVE_UP)
                        give_ups++;
                    if (int'(want.trial) > deepest)
                        deepest = want.trial;
                end
            end
        end

        o_fail_count    <= fails;
        o_pending       <= expected_results.size();
        o_engine_active <= (eng_phase != PH_IDLE);
        o_checked       <= checked;
        o_grants        <= grants;
        o_give_ups      <= give_ups;
        o_deepest_trial <= deepest;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Top of the carrier sense backoff testbench: clock, reset, register settings,
// input transactions and result back-pressure; csb_checker does the scoring.
// Depends on csb_pkg, carrier_sense_backoff_top and csb_checker.
module testbench;
    import csb_pkg::*;

    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int ITEMS_PER_SETTING = 215;
    localparam int DRAIN_CAP         = 12;
    localparam int TAIL_CYCLES       = 8;
    localparam int RSSI_MIN          = -160;
    localparam int RSSI_MAX          = 20;

    typedef struct {
        int threshold;
        int sense_len;
        int slot_len;
        int trials;
        int busy_pct;
    } t_csb_profile;

    typedef enum int {RX_OPEN, RX_CHOPPY, RX_CHOKED} t_rx_mode;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_A_W-1:0]         i_cfg_addr;
    logic [CFG_D_W-1:0]         i_cfg_wdata;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic                       i_start_req;
    logic signed [RSSI_W-1:0]   i_rssi_sample;
    logic [RAND_W-1:0]          i_random_value;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [STATUS_W-1:0]        o_status;
    logic [TRIAL_W-1:0]         o_trial;
    logic [BOFF_W-1:0]          o_backoff_ticks;

    int                         fail_count;
    int                         pending;
    logic                       engine_active;
    int                         checked;
    int                         grants;
    int                         give_ups;
    int                         deepest_trial;

    t_csb_profile               active_cfg;
    int                         burst_left = 0;
    int                         n_sent = 0;
    int                         n_settings = 0;
    t_rx_mode                   rx_mode = RX_OPEN;
    int                         rx_left = 0;
    int                         quiet_cycles = 0;

    carrier_sense_backoff_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_start_req     (i_start_req),
        .i_rssi_sample   (i_rssi_sample),
        .i_random_value  (i_random_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_trial         (o_trial),
        .o_backoff_ticks (o_backoff_ticks)
    );

    csb_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_start_req     (i_start_req),
        .i_rssi_sample   (i_rssi_sample),
        .i_random_value  (i_random_value),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_status        (o_status),
        .i_trial         (o_trial),
        .i_backoff_ticks (o_backoff_ticks),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_engine_active (engine_active),
        .o_checked       (checked),
        .o_grants        (grants),
        .o_give_ups      (give_ups),
        .o_deepest_trial (deepest_trial)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // uniform pick in [lo, hi]; folded to the sample width when driven
    function automatic int pick_rssi(input int lo, input int hi);
        int v;
        v = lo + int'($urandom_range(0, hi - lo));
        return v;
    endfunction

    // One input transaction; bursts of back-to-back items with random gaps between.
    task automatic send_txn(input logic start, input int rssi,
                            input logic [RAND_W-1:0] rnd);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_start_req    <= start;
        i_rssi_sample  <= RSSI_W'(rssi);
        i_random_value <= rnd;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    // Busy/quiet mix follows the current setting; a few samples use the full 9 bits.
    task automatic send_random_txn();
        logic                     start;
        int                       rssi;
        logic [RAND_W-1:0]        rnd;
        int                       roll;
        start = ($urandom_range(0, 99) < 35);
        roll = $urandom_range(0, 99);
        if (roll < 4)
            rssi = int'($urandom_range(0, 511)) - 256;
        else if (roll < 4 + active_cfg.busy_pct)
            rssi = pick_rssi(active_cfg.threshold + 1,
                             (active_cfg.threshold < RSSI_MAX) ? RSSI_MAX : 255);
        else
            rssi = pick_rssi(RSSI_MIN, active_cfg.threshold);
        // mostly short backoffs so sequences reach the later trials
        roll = $urandom_range(0, 99);
        if (roll < 88)
            rnd = RAND_W'($urandom_range(0, 7));
        else if (roll < 97)
            rnd = RAND_W'($urandom);
        else
            rnd = '1;
        send_txn(start, rssi, rnd);
    endtask

    task automatic wait_results();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Give a running sequence up to DRAIN_CAP quiet items to end, drain the pipe, then write all four registers.
    task automatic load_profile(input t_csb_profile prof);
        logic [CFG_A_W-1:0] ids [4];
        logic [CFG_D_W-1:0] vals [4];
        int                 drained;
        ids  = '{REG_RSSI_THRESHOLD, REG_SENSE_TICKS, REG_BACKOFF_UNIT, REG_MAX_TRIALS};
        vals = '{CFG_D_W'(prof.threshold), CFG_D_W'(prof.sense_len),
                 CFG_D_W'(prof.slot_len), CFG_D_W'(prof.trials)};
        drained = 0;
        while (engine_active && drained < DRAIN_CAP) begin
            send_txn(1'b0, pick_rssi(RSSI_MIN, active_cfg.threshold), RAND_W'($urandom));
            drained++;
        end
        i_in_valid <= 1'b0;
        wait_results();
        repeat (4) @(posedge i_clk);
        foreach (ids[k]) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= ids[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b0;
        active_cfg = prof;
        n_settings++;
    endtask

    // Stimulus and verdict
    initial begin
        t_csb_profile profiles [8];
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_addr     <= REG_RSSI_THRESHOLD;
        i_cfg_wdata    <= '0;
        i_in_valid     <= 1'b0;
        i_start_req    <= 1'b0;
        i_rssi_sample  <= '0;
        i_random_value <= '0;
        active_cfg = '{int'(RST_RSSI_THRESHOLD), int'(RST_SENSE_TICKS),
                       int'(RST_BACKOFF_UNIT), int'(RST_MAX_TRIALS), 0};
        profiles[0] = '{-80, 4, 3, 5, 30};
        profiles[1] = '{RSSI_MIN, 0, 0, 0, 50};        // zero window, slot and trial count
        profiles[2] = '{RSSI_MAX, 1, 1, 16, 90};
        profiles[3] = '{-100, 2, 2, 31, 85};           // trial count above 16
        profiles[4] = '{-60, 8, 5, 3, 15};
        profiles[5] = '{0, 1, 1, 16, 92};
        profiles[6] = '{-90, 3, 1, 8, 50};
        profiles[7] = '{-120, 65535, 65535, 2, 5};     // widest window and slot

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: three-tick window, one-tick slots, two trials
        load_profile('{-80, 3, 1, 2, 0});
        send_txn(1'b0, RSSI_MAX, 16'h0000);            // idle, no start
        send_txn(1'b1, -80, 16'hFFFF);                  // start; at threshold is not busy
        send_txn(1'b1, RSSI_MIN, 16'h0000);            // start while sensing is ignored
        send_txn(1'b0, -81, 16'h8000);                  // window complete: grant
        send_txn(1'b0, RSSI_MIN, 16'h0000);
        send_txn(1'b1, -79, 16'hFFFF);                  // busy on the start tick
        send_txn(1'b1, RSSI_MIN, 16'h0000);            // start during backoff ignored
        send_txn(1'b0, RSSI_MIN, 16'h0000);            // backoff expires
        send_txn(1'b0, RSSI_MAX, 16'h0000);            // busy on last trial: give up
        send_txn(1'b0, RSSI_MIN, 16'h0000);            // idle holds the last trial
        send_txn(1'b1, -256, 16'h5555);                 // 9-bit extremes
        send_txn(1'b0, 255, 16'hAAAA);
        send_txn(1'b0, RSSI_MIN, 16'h0000);
        send_txn(1'b0, RSSI_MIN, 16'h0000);
        send_txn(1'b0, RSSI_MIN, 16'h0000);
        send_txn(1'b0, RSSI_MIN, 16'h0000);

        // random sequences under each register setting
        foreach (profiles[p]) begin
            load_profile(profiles[p]);
            repeat (ITEMS_PER_SETTING) send_random_txn();
        end

        i_in_valid <= 1'b0;
        wait_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d input transactions over %0d register settings.",
                 n_sent, n_settings);
        $display("Checked %0d results: %0d grants, %0d give-ups, deepest trial %0d.",
                 checked, grants, give_ups, deepest_trial);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result back-pressure: open, choppy and choked stretches of random length
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(4, 48);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_CHOPPY: i_out_ready <= ($urandom_range(0, 1) == 1);
            default:   i_out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Watchdog: any transaction or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
